FILE: design/dcpc_pkg.sv
// dcpc_pkg: shared types and constants for the color point clustering block
// holds the payload structs, stored point layout, register indexes and sequencer states
// no dependencies
`default_nettype none

package dcpc_pkg;

  // input transaction payload
  typedef struct packed {
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [7:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        last;
  } in_t;

  // result transaction payload
  typedef struct packed {
    logic [5:0] point_index;
    logic       noise;
    logic [5:0] cluster_id;
    logic [6:0] cluster_count;
    logic       end_of_run;
  } out_t;

  // one stored point
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  h;
    logic [7:0]  s;
    logic [7:0]  v;
  } pt_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 34;
  localparam int unsigned ID_W       = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SQR_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_LIMIT  = 2'd2;

  localparam logic [33:0] MAX_SQR_DIST_RST = 34'd65536;
  localparam logic [6:0]  MIN_POINTS_RST   = 7'd10;
  localparam logic [19:0] COLOR_LIMIT_RST  = 20'd4000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PICK,
    ST_FETCH,
    ST_FETCH_W,
    ST_SCAN,
    ST_DEQ,
    ST_DEQ_W,
    ST_LABEL,
    ST_OUT_RD,
    ST_OUT_W,
    ST_OUT_HOLD
  } state_t;

  // what a neighbor scan is doing
  typedef enum logic [1:0] {
    MD_CNT_SEED,
    MD_CNT_QUEUED,
    MD_ENQ
  } mode_t;

  // absolute difference of two unsigned values
  function automatic logic [15:0] absd(input logic [15:0] a, input logic [15:0] b);
    absd = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

FILE: design/dcpc_ram.sv
// dcpc_ram: generic single write port, single read port ram
// read data is registered; no dependencies
`default_nettype none

module dcpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [$clog2(DEPTH)-1:0]    waddr,
  input  wire  [WIDTH-1:0]            wdata,
  input  wire  [$clog2(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/dbscan_color_point_cluster.sv
// dbscan_color_point_cluster: density clustering of colored image points
// uses dcpc_pkg and dcpc_ram (point store, cluster ids, expansion queue)
//
// Usage: points arrive on the in_ channel (valid/stall), one per transaction, and
// are stored in load order; at most MAX_POINTS are held, later ones are dropped.
// A transaction with last set starts clustering of the held set. in_stall is high
// from then on until every label has been delivered. One result transaction per
// held point then leaves on the out_ channel in load order, end_of_run on the final.
// Loading takes one cycle per point. Clustering is done by one shared pair test
// pipeline that streams the point store, one stored point per cycle: each neighbor
// scan covers all held points, and every point gets one counting scan plus one
// queueing scan if it is a core point, with pick, dequeue, fetch and label steps
// around them, then the labels are read out from the cluster id store.
// A stalled label stays in the output register until taken; nothing else moves.
// Reset (rst_n low, synchronous) empties the set and restores the register
// defaults; configuration is written through cfg_we/cfg_index/cfg_wdata.
`default_nettype none

module dbscan_color_point_cluster #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  dcpc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output dcpc_pkg::out_t                    out_data,
  input  wire                               cfg_we,
  input  wire  [dcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dcpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import dcpc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // configuration registers
  logic [33:0] max_sqr_r;
  logic [6:0]  min_pts_r;
  logic [19:0] color_lim_r;

  // sequencer state
  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     clus_r, clus_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     scan_j_r, scan_j_nxt;
  logic [CW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     tail_r, tail_nxt;
  logic [IW-1:0]     a_r, a_nxt;
  logic [MAX_POINTS-1:0] visited_r, visited_nxt;
  logic [MAX_POINTS-1:0] member_r, member_nxt;
  logic [MAX_POINTS-1:0] queued_r, queued_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  // ram ports
  logic              pt_we;
  logic [IW-1:0]     pt_raddr;
  logic [$bits(pt_t)-1:0] pt_rdata;
  logic              id_we;
  logic [IW-1:0]     id_waddr;
  logic [ID_W-1:0]   id_rdata;
  logic              q_we;
  logic [IW-1:0]     q_rdata;

  // pair test pipeline
  pt_t               pa_r;
  pt_t               pb;
  logic              scan_issue;
  logic              scan_done;
  logic              p1_v_r, p2_v_r, p3_v_r;
  logic [IW-1:0]     p1_j_r, p2_j_r, p3_j_r;
  logic [15:0]       dx_r, dy_r;
  logic [7:0]        dh_r, ds_r, dv_r;
  logic [31:0]       sx_r, sy_r;
  logic [15:0]       sh_r, ss_r, sv_r;
  logic [33:0]       dist_sum;
  logic [20:0]       col_sum;
  logic              hit;
  logic              in_acc;
  logic              is_noise;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sqr_r   <= MAX_SQR_DIST_RST;
      min_pts_r   <= MIN_POINTS_RST;
      color_lim_r <= COLOR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SQR_DIST: max_sqr_r   <= cfg_wdata;
        REG_MIN_POINTS:   min_pts_r   <= cfg_wdata[6:0];
        REG_COLOR_LIMIT:  color_lim_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // point store
  assign pt_we = in_acc && (n_r < CW'(MAX_POINTS));
  assign pt_raddr = (state_r == ST_FETCH) ? a_r : scan_j_r[IW-1:0];

  dcpc_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (n_r[IW-1:0]),
    .wdata ({in_data.x_pos, in_data.y_pos, in_data.hue, in_data.sat, in_data.val}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // cluster id store, valid only where member_r is set
  dcpc_ram #(.WIDTH(ID_W), .DEPTH(MAX_POINTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (ID_W'(clus_r)),
    .raddr (k_r[IW-1:0]),
    .rdata (id_rdata)
  );

  // expansion queue
  dcpc_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r[IW-1:0]),
    .wdata (p3_j_r),
    .raddr (head_r[IW-1:0]),
    .rdata (q_rdata)
  );

  // pair test: stream store entries against the held point
  assign pb = pt_t'(pt_rdata);
  assign scan_issue = (state_r == ST_SCAN) && (scan_j_r < n_r);
  assign scan_done = (state_r == ST_SCAN) && !scan_issue && !p1_v_r && !p2_v_r && !p3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= scan_issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_j_r <= scan_j_r[IW-1:0];
    p2_j_r <= p1_j_r;
    p3_j_r <= p2_j_r;
    dx_r <= absd(pa_r.x, pb.x);
    dy_r <= absd(pa_r.y, pb.y);
    dh_r <= 8'(absd({8'd0, pa_r.h}, {8'd0, pb.h}));
    ds_r <= 8'(absd({8'd0, pa_r.s}, {8'd0, pb.s}));
    dv_r <= 8'(absd({8'd0, pa_r.v}, {8'd0, pb.v}));
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    sh_r <= dh_r * dh_r;
    ss_r <= ds_r * ds_r;
    sv_r <= dv_r * dv_r;
  end

  // held point capture
  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH_W) begin
      pa_r <= pb;
    end
  end

  // neighbor decision, points already in a cluster never count
  assign dist_sum = {2'b0, sx_r} + {2'b0, sy_r};
  assign col_sum  = {2'b0, sh_r, 3'b0} + {4'b0, sh_r, 1'b0} + {5'b0, ss_r} + {5'b0, sv_r};
  assign hit = p3_v_r && !member_r[p3_j_r] && (dist_sum <= max_sqr_r) &&
               (col_sum <= {1'b0, color_lim_r});
  assign is_noise = !member_r[k_r[IW-1:0]];

  // state register and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      mode_r      <= MD_CNT_SEED;
      n_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      clus_r      <= '0;
      cnt_r       <= '0;
      scan_j_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      a_r         <= '0;
      visited_r   <= '0;
      member_r    <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      clus_r      <= clus_nxt;
      cnt_r       <= cnt_nxt;
      scan_j_r    <= scan_j_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      a_r         <= a_nxt;
      visited_r   <= visited_nxt;
      member_r    <= member_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    clus_nxt      = clus_r;
    cnt_nxt       = cnt_r;
    scan_j_nxt    = scan_j_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    a_nxt         = a_r;
    visited_nxt   = visited_r;
    member_nxt    = member_r;
    queued_nxt    = queued_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    id_we         = 1'b0;
    id_waddr      = a_r;
    q_we          = 1'b0;

    unique case (state_r)
      // take points until last
      ST_LOAD: begin
        if (in_acc) begin
          if (n_r < CW'(MAX_POINTS)) begin
            n_nxt = n_r + CW'(1);
          end
          if (in_data.last) begin
            i_nxt     = '0;
            clus_nxt  = '0;
            state_nxt = ST_PICK;
          end
        end
      end
      // next unvisited seed point
      ST_PICK: begin
        if (i_r == n_r) begin
          k_nxt     = '0;
          state_nxt = ST_OUT_RD;
        end else if (visited_r[i_r[IW-1:0]]) begin
          i_nxt = i_r + CW'(1);
        end else begin
          visited_nxt[i_r[IW-1:0]] = 1'b1;
          a_nxt     = i_r[IW-1:0];
          mode_nxt  = MD_CNT_SEED;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_FETCH_W;
      end
      ST_FETCH_W: begin
        scan_j_nxt = '0;
        cnt_nxt    = '0;
        state_nxt  = ST_SCAN;
      end
      // streaming neighbor scan
      ST_SCAN: begin
        if (scan_issue) begin
          scan_j_nxt = scan_j_r + CW'(1);
        end
        if (hit) begin
          if (mode_r == MD_ENQ) begin
            if (!queued_r[p3_j_r]) begin
              queued_nxt[p3_j_r] = 1'b1;
              q_we     = 1'b1;
              tail_nxt = tail_r + CW'(1);
            end
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        if (scan_done) begin
          unique case (mode_r)
            MD_CNT_SEED: begin
              if (7'(cnt_r) < min_pts_r) begin
                i_nxt     = i_r + CW'(1);
                state_nxt = ST_PICK;
              end else begin
                member_nxt[a_r] = 1'b1;
                id_we      = 1'b1;
                head_nxt   = '0;
                tail_nxt   = '0;
                mode_nxt   = MD_ENQ;
                scan_j_nxt = '0;
              end
            end
            MD_CNT_QUEUED: begin
              if (7'(cnt_r) < min_pts_r) begin
                state_nxt = ST_LABEL;
              end else begin
                mode_nxt   = MD_ENQ;
                scan_j_nxt = '0;
              end
            end
            MD_ENQ: begin
              state_nxt = ST_LABEL;
            end
            default: ;
          endcase
        end
      end
      // pop the expansion queue
      ST_DEQ: begin
        if (head_r == tail_r) begin
          clus_nxt  = clus_r + CW'(1);
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_PICK;
        end else begin
          state_nxt = ST_DEQ_W;
        end
      end
      ST_DEQ_W: begin
        a_nxt    = q_rdata;
        head_nxt = head_r + CW'(1);
        if (!visited_r[q_rdata]) begin
          visited_nxt[q_rdata] = 1'b1;
          mode_nxt  = MD_CNT_QUEUED;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_LABEL;
        end
      end
      // join the current cluster if not in one yet
      ST_LABEL: begin
        if (!member_r[a_r]) begin
          member_nxt[a_r] = 1'b1;
          id_we = 1'b1;
        end
        state_nxt = ST_DEQ;
      end
      // label readout
      ST_OUT_RD: begin
        state_nxt = ST_OUT_W;
      end
      ST_OUT_W: begin
        out_data_nxt.point_index   = 6'(k_r);
        out_data_nxt.noise         = is_noise;
        out_data_nxt.cluster_id    = is_noise ? 6'd0 : 6'(id_rdata);
        out_data_nxt.cluster_count = 7'(clus_r);
        out_data_nxt.end_of_run    = ((k_r + CW'(1)) == n_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if ((k_r + CW'(1)) == n_r) begin
            n_nxt       = '0;
            visited_nxt = '0;
            member_nxt  = '0;
            queued_nxt  = '0;
            state_nxt   = ST_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dcpc_checker.sv
// dcpc_checker: port level checks for dbscan_color_point_cluster
// uses dcpc_pkg; bound to the top level below
`default_nettype none

module dcpc_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_stall,
  input wire            out_valid,
  input wire            out_stall,
  input dcpc_pkg::out_t out_data
);

  import dcpc_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no point is taken while labels are going out
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during label output");

  // the end of a run is followed by a gap
  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.end_of_run |=> !out_valid)
    else $error("result after end of run");

  // noise carries a zero cluster id
  a_noise_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.noise |-> out_data.cluster_id == 6'd0)
    else $error("noise with cluster id");

  // cluster id below the cluster count
  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.noise |-> {1'b0, out_data.cluster_id} < out_data.cluster_count)
    else $error("cluster id out of range");

endmodule

bind dbscan_color_point_cluster dcpc_checker u_dcpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for dbscan_color_point_cluster
// depends on dcpc_pkg and the design sources; predicts every label with its own clustering model
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import dcpc_pkg::*;

  localparam int HOLD_MAX   = 64;
  localparam int LBL_UNSEEN = -1;
  localparam int LBL_SEEN   = -2;
  localparam int LBL_NOISE  = -3;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dbscan_color_point_cluster uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state: register copies and the held point set
  logic [33:0] radius_sq;
  int          core_min;
  logic [19:0] color_lim;
  pt_t         held_pts[HOLD_MAX];
  int          held_cnt;
  int          lbl[HOLD_MAX];
  bit          queued[HOLD_MAX];
  int          grow_q[HOLD_MAX];
  int          q_head, q_tail;

  out_t   expected_labels[$];
  int     fail_cnt;
  int     set_cnt;
  int     label_cnt;
  int     items_sent;
  int     hold_off;
  bit     no_idle;
  longint cycles;

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --- clustering predictor ---
  function automatic bit is_near(int a, int b);
    longint unsigned dx, dy, dh, ds, dv;
    dx = (held_pts[a].x > held_pts[b].x) ? held_pts[a].x - held_pts[b].x
                                          : held_pts[b].x - held_pts[a].x;
    dy = (held_pts[a].y > held_pts[b].y) ? held_pts[a].y - held_pts[b].y
                                          : held_pts[b].y - held_pts[a].y;
    dh = (held_pts[a].h > held_pts[b].h) ? held_pts[a].h - held_pts[b].h
                                          : held_pts[b].h - held_pts[a].h;
    ds = (held_pts[a].s > held_pts[b].s) ? held_pts[a].s - held_pts[b].s
                                          : held_pts[b].s - held_pts[a].s;
    dv = (held_pts[a].v > held_pts[b].v) ? held_pts[a].v - held_pts[b].v
                                          : held_pts[b].v - held_pts[a].v;
    if (dx * dx + dy * dy > radius_sq) return 1'b0;
    return (10 * dh * dh + ds * ds + dv * dv) <= color_lim;
  endfunction

  // points already in a cluster are skipped
  function automatic int density_of(int a);
    int n;
    n = 0;
    for (int j = 0; j < held_cnt; j++)
      if (lbl[j] < 0 && is_near(a, j)) n++;
    return n;
  endfunction

  function automatic void queue_near(int a);
    for (int j = 0; j < held_cnt; j++) begin
      if (lbl[j] >= 0 || queued[j]) continue;
      if (!is_near(a, j)) continue;
      if (q_tail < HOLD_MAX) begin
        queued[j] = 1'b1;
        grow_q[q_tail] = j;
        q_tail++;
      end
    end
  endfunction

  function automatic void label_held_set();
    int   nc, k;
    out_t r;
    nc = 0;
    for (int i = 0; i < held_cnt; i++) begin
      if (lbl[i] != LBL_UNSEEN) continue;
      lbl[i] = LBL_SEEN;
      if (density_of(i) < core_min) begin
        lbl[i] = LBL_NOISE;
        continue;
      end
      q_head = 0;
      q_tail = 0;
      queue_near(i);
      lbl[i] = nc;
      while (q_head < q_tail) begin
        k = grow_q[q_head];
        q_head++;
        if (lbl[k] == LBL_UNSEEN) begin
          lbl[k] = LBL_SEEN;
          if (density_of(k) >= core_min) queue_near(k);
        end
        if (lbl[k] < 0) lbl[k] = nc;
      end
      nc++;
    end
    for (int i = 0; i < held_cnt; i++) begin
      r.point_index   = i[5:0];
      r.noise         = (lbl[i] < 0);
      r.cluster_id    = (lbl[i] < 0) ? 6'd0 : lbl[i][5:0];
      r.cluster_count = nc[6:0];
      r.end_of_run    = (i + 1 == held_cnt);
      expected_labels.insert(expected_labels.size(), r);
    end
    if (held_cnt > 0) set_cnt++;
    held_cnt = 0;
    for (int i = 0; i < HOLD_MAX; i++) begin
      lbl[i] = LBL_UNSEEN;
      queued[i] = 1'b0;
    end
  endfunction

  function automatic void accept_point(in_t p);
    if (held_cnt < HOLD_MAX) begin
      held_pts[held_cnt] = '{x: p.x_pos, y: p.y_pos, h: p.hue, s: p.sat, v: p.val};
      lbl[held_cnt] = LBL_UNSEEN;
      held_cnt++;
    end
    if (p.last) label_held_set();
  endfunction

  // --- input side ---
  // leaves valid high on return; the next call or release_input settles it
  task automatic send_point(in_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    accept_point(p);
    items_sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    release_input();
    while (expected_labels.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_SQR_DIST: radius_sq = d[33:0];
      REG_MIN_POINTS:   core_min  = d[6:0];
      REG_COLOR_LIMIT:  color_lim = d[19:0];
      default: ;
    endcase
  endtask

  function automatic in_t mk_pt(int x, int y, int h, int s, int v, bit lst);
    in_t p;
    p.x_pos = x[15:0];
    p.y_pos = y[15:0];
    p.hue = h[7:0];
    p.sat = s[7:0];
    p.val = v[7:0];
    p.last = lst;
    return p;
  endfunction

  function automatic in_t any_pt(bit lst);
    return mk_pt($urandom, $urandom, $urandom, $urandom, $urandom, lst);
  endfunction

  // --- result side ---
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_labels.size() == 0) begin
        $error("unexpected label transaction for point %0d", out_data.point_index);
        fail_cnt++;
      end else begin
        out_t e;
        e = expected_labels.pop_front();
        label_cnt++;
        if (out_data.point_index !== e.point_index) begin
          $error("point_index exp %0d got %0d", e.point_index, out_data.point_index);
          fail_cnt++;
        end
        if (out_data.noise !== e.noise) begin
          $error("noise exp %0d got %0d", e.noise, out_data.noise);
          fail_cnt++;
        end
        if (out_data.cluster_id !== e.cluster_id) begin
          $error("cluster_id exp %0d got %0d", e.cluster_id, out_data.cluster_id);
          fail_cnt++;
        end
        if (out_data.cluster_count !== e.cluster_count) begin
          $error("cluster_count exp %0d got %0d", e.cluster_count, out_data.cluster_count);
          fail_cnt++;
        end
        if (out_data.end_of_run !== e.end_of_run) begin
          $error("end_of_run exp %0d got %0d", e.end_of_run, out_data.end_of_run);
          fail_cnt++;
        end
      end
    end
    // stall pattern: forced hold-off first, never stalled in no_idle mode, else random
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) out_stall <= 1'b0;
      else if (r < 97) out_stall <= 1'b1;
      else hold_off <= $urandom_range(10, 40);
    end
  end

  // --- tests ---
  task automatic test_extremes();
    write_reg(REG_MIN_POINTS, 34'd1);
    send_point(mk_pt(0, 0, 0, 0, 0, 1'b0));
    send_point(mk_pt(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_point(mk_pt(16'h1234, 16'h4321, 8'h80, 8'h01, 8'hFE, 1'b1));
    write_reg(REG_MAX_SQR_DIST, 34'h3_FFFF_FFFF);
    write_reg(REG_COLOR_LIMIT, 34'hF_FFFF);
    write_reg(REG_MIN_POINTS, 34'd2);
    send_point(mk_pt(0, 0, 0, 0, 0, 1'b0));
    send_point(mk_pt(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_point(mk_pt(16'hFFFF, 0, 8'hFF, 0, 8'hFF, 1'b1));
    // zero core threshold: every unvisited point is a core point
    write_reg(REG_MIN_POINTS, 34'd0);
    write_reg(REG_MAX_SQR_DIST, 34'd0);
    write_reg(REG_COLOR_LIMIT, 34'd0);
    send_point(mk_pt(100, 100, 10, 10, 10, 1'b0));
    send_point(mk_pt(100, 100, 10, 10, 10, 1'b0));
    send_point(mk_pt(101, 100, 10, 10, 10, 1'b1));
    // threshold above set size: all noise
    write_reg(REG_MIN_POINTS, 34'd127);
    write_reg(REG_MAX_SQR_DIST, 34'd65536);
    write_reg(REG_COLOR_LIMIT, 34'd780300);
    for (int i = 0; i < 4; i++) send_point(mk_pt(50 + i, 50, 20, 20, 20, i == 3));
    // an out-of-range index must be ignored
    write_reg(REG_UNUSED, 34'h0_0000_0003);
    write_reg(REG_MIN_POINTS, 34'd3);
    for (int i = 0; i < 6; i++)
      send_point(mk_pt(200 + 16 * i, 300, 40 + i, 90, 90 - i, i == 5));
    release_input();
  endtask

  // beyond the store size points are dropped, last still starts the run
  task automatic test_overflow();
    write_reg(REG_MIN_POINTS, 34'd4);
    write_reg(REG_MAX_SQR_DIST, 34'd4096);
    write_reg(REG_COLOR_LIMIT, 34'd4000);
    for (int i = 0; i < 70; i++)
      send_point(mk_pt($urandom_range(0, 400), $urandom_range(0, 400),
                       $urandom_range(0, 30), $urandom_range(0, 30),
                       $urandom_range(0, 30), i == 69));
    release_input();
  endtask

  // receiver holds off while the sender keeps pushing sets
  task automatic test_backpressure();
    wait_idle();
    // set between edges so the stall process never writes it in the same step
    @(negedge clk);
    hold_off = 3000;
    @(posedge clk);
    for (int s = 0; s < 3; s++)
      for (int i = 0; i < 8; i++)
        send_point(mk_pt(1000 + $urandom_range(0, 200), 2000 + $urandom_range(0, 200),
                         $urandom_range(60, 70), $urandom_range(60, 70),
                         $urandom_range(60, 70), i == 7));
    release_input();
  endtask

  // random sets built around a few color/position blobs, some pure noise
  task automatic test_random_sets();
    int n, blobs, b, spread, cspread;
    int cx[4], cy[4], ch[4], cs[4], cv[4];
    while (items_sent < 330) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_MAX_SQR_DIST, $urandom_range(0, 3) == 0 ?
                       CFG_DATA_W'({$urandom, $urandom}) :
                       CFG_DATA_W'($urandom_range(0, 200000)));
          1: write_reg(REG_MIN_POINTS, $urandom_range(0, 9) == 0 ?
                       CFG_DATA_W'($urandom_range(0, 127)) :
                       CFG_DATA_W'($urandom_range(1, 6)));
          default: write_reg(REG_COLOR_LIMIT, $urandom_range(0, 4) == 0 ?
                             CFG_DATA_W'($urandom_range(0, 1048575)) :
                             CFG_DATA_W'($urandom_range(0, 8000)));
        endcase
      end
      no_idle = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(1, 14);
      blobs = $urandom_range(1, 3);
      spread = $urandom_range(4, 600);
      cspread = $urandom_range(1, 40);
      for (int k = 0; k < 4; k++) begin
        cx[k] = $urandom_range(0, 65535 - 700);
        cy[k] = $urandom_range(0, 65535 - 700);
        ch[k] = $urandom_range(0, 255 - 45);
        cs[k] = $urandom_range(0, 255 - 45);
        cv[k] = $urandom_range(0, 255 - 45);
      end
      for (int i = 0; i < n; i++) begin
        b = $urandom_range(0, blobs - 1);
        if ($urandom_range(0, 5) == 0) send_point(any_pt(i == n - 1));
        else send_point(mk_pt(cx[b] + $urandom_range(0, spread),
                              cy[b] + $urandom_range(0, spread),
                              ch[b] + $urandom_range(0, cspread),
                              cs[b] + $urandom_range(0, cspread),
                              cv[b] + $urandom_range(0, cspread), i == n - 1));
      end
    end
    no_idle = 1'b0;
    release_input();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles = 0;
    fail_cnt = 0;
    set_cnt = 0;
    label_cnt = 0;
    items_sent = 0;
    hold_off = 0;
    no_idle = 1'b0;
    radius_sq = MAX_SQR_DIST_RST;
    core_min = MIN_POINTS_RST;
    color_lim = COLOR_LIMIT_RST;
    held_cnt = 0;
    for (int i = 0; i < HOLD_MAX; i++) begin
      lbl[i] = LBL_UNSEEN;
      queued[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first, then the named tests
    for (int i = 0; i < 5; i++)
      send_point(mk_pt(500 + 8 * i, 500, 30, 30, 30, i == 4));
    release_input();
    test_extremes();
    test_overflow();
    test_backpressure();
    test_random_sets();

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d points in %0d sets, %0d labels checked",
             items_sent, set_cnt, label_cnt);
    $display("register extremes, store overflow and long output hold-off exercised");
    if (fail_cnt == 0 && expected_labels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
